// ===== sv/cgpc_pkg.sv =====
// package: shared types, constants and helpers of the channel gain/pedestal checker
`timescale 1ns / 1ps
package cgpc_pkg;

    localparam int CHANNELS  = 8192;
    localparam int CH_BITS   = $clog2(CHANNELS);
    localparam int ADC_BITS  = 12;
    localparam int ADDR_BITS = 3;

    localparam logic [15:0] DEFAULT_TOL = 16'd66;

    // register byte addresses
    localparam logic [ADDR_BITS-1:0] REG_GAIN_TOL = 3'd0;
    localparam logic [ADDR_BITS-1:0] REG_PED_TOL  = 3'd4;

    // one stored entry of the channel table
    typedef struct packed {
        logic [2:0]          flags;      // {all, ped, gain}
        logic signed [31:0]  ped;
        logic signed [31:0]  gain;
        logic [15:0]         count;
        logic signed [31:0]  ref_e;
        logic [ADC_BITS-1:0] ref_adc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // divider request / response
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/cgpc_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module cgpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/cgpc_div.sv =====
// shared iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module cgpc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  cgpc_pkg::div_req_t  req,
    output cgpc_pkg::div_rsp_t  rsp
);
    import cgpc_pkg::*;

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic        done_reg;

    logic [64:0] trial;
    logic [63:0] rem_sh;

    always_comb begin
        rem_sh = {rem_reg[62:0], quo_reg[63]};
        trial  = {1'b0, rem_sh} - {1'b0, den_reg};
    end

    // restoring division on magnitudes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                rem_reg  <= '0;
                quo_reg  <= req.num[63] ? 64'(-req.num) : req.num;
                den_reg  <= req.den[63] ? 64'(-req.den) : req.den;
                neg_reg  <= req.num[63] ^ req.den[63];
            end else if (busy_reg) begin
                if (!trial[64]) begin
                    rem_reg <= trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? 64'(-quo_reg) : quo_reg;
endmodule

// ===== sv/channel_gain_pedestal_checker.sv =====
// top level: per-channel gain and pedestal consistency checker
// samples needing no division skip the divider; others wait on the shared divider
// throughput: one sample at a time; the 64-step shared divider sets the rate
// after reset a clearing pass sweeps all 8192 table entries, s_tready stays low
// reset: synchronous active-low aresetn; tolerances return to 66
`timescale 1ns / 1ps
module channel_gain_pedestal_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // channel[12:0], adc_count[24:13], energy[56:25], zeros
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [87:0] m_tdata    // entry_count, gain_value, pedestal_value, gain_c,
                                   // pedestal_c, all_c, zeros
);
    import cgpc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_GDIV, ST_PSTART, ST_PDIV,
        ST_CHECK, ST_WRITE, ST_OUT
    } state_t;

    state_t              state_reg;
    logic [CH_BITS-1:0]  clr_reg;
    logic [15:0]         gtol_reg, ptol_reg;
    logic [CH_BITS-1:0]  ch_reg;
    logic [ADC_BITS-1:0] adc_reg;
    logic signed [31:0]  e_reg;
    entry_t              ent_reg;
    entry_t              ent_next;
    logic                dec_div;
    logic signed [31:0]  g_reg, p_reg;
    logic                pres_reg;
    logic [87:0]         out_reg;

    // storage
    logic                ram_we;
    logic [CH_BITS-1:0]  ram_addr;
    logic [ENTRY_W:0]    ram_wdata, ram_rdata;
    entry_t              rd_ent;
    div_req_t            dreq;
    div_rsp_t            drsp;

    cgpc_ram #(.WIDTH(ENTRY_W + 1), .DEPTH(CHANNELS)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );
    cgpc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign rd_ent = entry_t'(ram_rdata[ENTRY_W-1:0]);

    // table port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = ch_reg;
        ram_wdata = {pres_reg, ent_reg};
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = {1'b0, 3'b111, {(ENTRY_W-3){1'b0}}};
        end else if (state_reg == ST_WRITE) begin
            ram_we = 1'b1;
        end
    end

    logic [63:0] gdiff, pdiff;
    always_comb begin
        gdiff = 64'(g_reg) - 64'(ent_reg.gain);
        if (gdiff[63]) gdiff = -gdiff;
        pdiff = 64'(p_reg) - 64'(ent_reg.ped);
        if (pdiff[63]) pdiff = -pdiff;
    end

    // next entry: sample decision on the fresh table word, tolerance check later
    always_comb begin
        ent_next = ent_reg;
        dec_div  = 1'b0;
        if (state_reg == ST_DECIDE) begin
            ent_next = rd_ent;
            if (!ram_rdata[ENTRY_W]) begin
                if (adc_reg != '0 || e_reg != 0) begin
                    ent_next.ref_adc = adc_reg;
                    ent_next.ref_e   = e_reg;
                    ent_next.count   = 16'd1;
                end
            end else if (adc_reg != '0 && e_reg != 0) begin
                if (rd_ent.count != 16'hffff) ent_next.count = rd_ent.count + 16'd1;
                if (rd_ent.ref_adc == '0 || rd_ent.ref_e == 0) begin
                    ent_next.ref_adc = adc_reg;
                    ent_next.ref_e   = e_reg;
                end else if (rd_ent.ref_adc == adc_reg) begin
                    if (rd_ent.ref_e != e_reg) ent_next.flags[2] = 1'b0;
                end else begin
                    dec_div = 1'b1;
                end
            end
        end else if (state_reg == ST_CHECK) begin
            if (ent_reg.gain == 0) begin
                ent_next.gain = g_reg;
                ent_next.ped  = p_reg;
            end else begin
                if (gdiff > 64'(gtol_reg)) begin
                    ent_next.flags[0] = 1'b0;
                    ent_next.flags[2] = 1'b0;
                end
                if (pdiff > 64'(ptol_reg)) begin
                    ent_next.flags[1] = 1'b0;
                    ent_next.flags[2] = 1'b0;
                end
            end
        end
    end

    // divider requests: gain then scaled energy over gain
    always_comb begin
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        if (state_reg == ST_DECIDE) begin
            dreq.start = dec_div;
            dreq.num   = 64'(rd_ent.ref_e) - 64'(e_reg);
            dreq.den   = 64'(signed'({1'b0, rd_ent.ref_adc}))
                         - 64'(signed'({1'b0, adc_reg}));
        end else if (state_reg == ST_PSTART) begin
            dreq.start = 1'b1;
            dreq.num   = 64'(e_reg) <<< 16;
            dreq.den   = 64'(g_reg);
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_PED_TOL) ? {16'd0, ptol_reg} : {16'd0, gtol_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            gtol_reg  <= DEFAULT_TOL;
            ptol_reg  <= DEFAULT_TOL;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == REG_GAIN_TOL) gtol_reg <= pwdata[15:0];
                else if (paddr == REG_PED_TOL) ptol_reg <= pwdata[15:0];
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CH_BITS'(CHANNELS - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ch_reg    <= s_tdata[CH_BITS-1:0];
                        adc_reg   <= s_tdata[13 +: ADC_BITS];
                        e_reg     <= s_tdata[56:25];
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    // ram data valid here
                    ent_reg   <= ent_next;
                    pres_reg  <= 1'b1;
                    state_reg <= dec_div ? ST_GDIV : ST_WRITE;
                end
                ST_GDIV: begin
                    if (drsp.done) begin
                        g_reg <= sat32(drsp.quo);
                        if (sat32(drsp.quo) == 0) begin
                            p_reg     <= (e_reg > 0) ? 32'sh80000000 : 32'sh7fffffff;
                            state_reg <= ST_CHECK;
                        end else begin
                            state_reg <= ST_PSTART;
                        end
                    end
                end
                ST_PSTART: begin
                    state_reg <= ST_PDIV;
                end
                ST_PDIV: begin
                    if (drsp.done) begin
                        p_reg <= sat32((64'(signed'({1'b0, adc_reg})) <<< 16) - drsp.quo);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    ent_reg   <= ent_next;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    out_reg <= {5'd0, ent_reg.flags, ent_reg.ped, ent_reg.gain,
                                ent_reg.count};
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
